[sv/aabb_fc_pkg.sv]
// ---------------------------------------------------------------------------
// aabb_fc_pkg
// Shared types and constants for the box frustum culling core.
// ---------------------------------------------------------------------------
package aabb_fc_pkg;

    localparam int COORD_WIDTH_DEF = 20;
    localparam int DIR_WIDTH_DEF   = 16;

    localparam int TAN_W       = 16;
    localparam int TAN_FRAC    = 12;
    localparam int DIST_W      = 19;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 6;
    localparam int TDATA_OUT_W = 8;

    localparam logic [TAN_W-1:0]  TAN_V_RST = 16'd2365;
    localparam logic [TAN_W-1:0]  TAN_H_RST = 16'd4204;
    localparam logic [DIST_W-1:0] NEAR_RST  = 19'd1;
    localparam logic [DIST_W-1:0] FAR_RST   = 19'd64000;

    typedef enum logic [2:0] {
        REG_CAM_POS,
        REG_CAM_FWD,
        REG_CAM_RGT,
        REG_CAM_UP,
        REG_TAN_V,
        REG_TAN_H,
        REG_NEAR,
        REG_FAR
    } t_reg_idx;

    // Camera registers, each vector zero-extended to the full data width.
    typedef struct packed {
        logic [CFG_DATA_W-1:0] cam_pos;
        logic [CFG_DATA_W-1:0] cam_fwd;
        logic [CFG_DATA_W-1:0] cam_rgt;
        logic [CFG_DATA_W-1:0] cam_up;
        logic [TAN_W-1:0]      tan_v;
        logic [TAN_W-1:0]      tan_h;
        logic [DIST_W-1:0]     near_dist;
        logic [DIST_W-1:0]     far_dist;
    } t_cfg;

endpackage

[sv/aabb_frustum_cull_core.sv]
// ---------------------------------------------------------------------------
// aabb_frustum_cull_core
// View-frustum culling of axis-aligned boxes, one box per clock while the output is not stalled.
//
//   Channel  | Dir | Signals                      | Transfer carries
//   ---------+-----+------------------------------+----------------------------
//   s_*      | in  | s_tvalid s_tready s_tdata    | one box, min/max corners
//   m_*      | out | m_tvalid m_tready m_tdata    | visible flag
//   APB      | in  | psel penable pwrite paddr .. | camera register write/read
//
// Six register stages: prep, products, sums, near/far, tangent products,
// decision. One box per cycle is sustained while the output is not stalled.
// Each stage has its own valid bit and loads when it is empty or the stage
// after it moves, so bubbles close up under a stalled output.
// Synchronous active-low reset clears all valid bits and loads register
// reset values.
// ---------------------------------------------------------------------------
module aabb_frustum_cull_core #(
    parameter int COORD_WIDTH = aabb_fc_pkg::COORD_WIDTH_DEF,
    parameter int DIR_WIDTH   = aabb_fc_pkg::DIR_WIDTH_DEF,
    localparam int S_TDATA_W  = ((6 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // min_x, min_y, min_z, max_x, max_y, max_z (lowest first), zero pad
    input  logic [S_TDATA_W-1:0]                s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // visible in bit 0, zero pad
    output logic [aabb_fc_pkg::TDATA_OUT_W-1:0] m_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [aabb_fc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [aabb_fc_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [aabb_fc_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                pready
);
    localparam int CW    = COORD_WIDTH;
    localparam int DW    = DIR_WIDTH;
    localparam int OUT_W = aabb_fc_pkg::TDATA_OUT_W;

    aabb_fc_pkg::t_cfg          cfg;
    logic signed [CW-1:0]       box_min [3];
    logic signed [CW-1:0]       box_max [3];

    logic                       p1_valid;
    logic                       p1_ready;
    logic signed [CW+1:0]       p1_tc [3];
    logic signed [CW:0]         p1_ex [3];
    logic                       p1_degen;
    logic                       p1_inside;

    logic                       p3_valid;
    logic                       p3_ready;
    logic signed [CW+DW+3:0]    p3_ctr [3];
    logic signed [CW+DW+3:0]    p3_rad [3];
    logic                       p3_degen;
    logic                       p3_inside;

    logic                       vis;

    for (genvar i = 0; i < 3; i++) begin : g_unpack
        assign box_min[i] = s_tdata[i*CW +: CW];
        assign box_max[i] = s_tdata[(i+3)*CW +: CW];
    end

    assign pready = 1'b1;

    aabb_fc_regs #(
        .CW (CW),
        .DW (DW)
    ) u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (cfg)
    );

    aabb_fc_prep #(
        .CW (CW)
    ) u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_tvalid),
        .o_ready  (s_tready),
        .i_min    (box_min),
        .i_max    (box_max),
        .i_cfg    (cfg),
        .o_valid  (p1_valid),
        .i_ready  (p1_ready),
        .o_tc     (p1_tc),
        .o_ex     (p1_ex),
        .o_degen  (p1_degen),
        .o_inside (p1_inside)
    );

    aabb_fc_dot #(
        .CW (CW),
        .DW (DW)
    ) u_dot (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (p1_valid),
        .o_ready  (p1_ready),
        .i_tc     (p1_tc),
        .i_ex     (p1_ex),
        .i_degen  (p1_degen),
        .i_inside (p1_inside),
        .i_cfg    (cfg),
        .o_valid  (p3_valid),
        .i_ready  (p3_ready),
        .o_ctr    (p3_ctr),
        .o_rad    (p3_rad),
        .o_degen  (p3_degen),
        .o_inside (p3_inside)
    );

    aabb_fc_test #(
        .CW (CW),
        .DW (DW)
    ) u_test (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (p3_valid),
        .o_ready   (p3_ready),
        .i_ctr     (p3_ctr),
        .i_rad     (p3_rad),
        .i_degen   (p3_degen),
        .i_inside  (p3_inside),
        .i_cfg     (cfg),
        .o_valid   (m_tvalid),
        .i_ready   (m_tready),
        .o_visible (vis)
    );

    assign m_tdata = {{(OUT_W-1){1'b0}}, vis};

endmodule

[sv/aabb_fc_regs.sv]
// ---------------------------------------------------------------------------
// aabb_fc_regs
// Camera register file behind the APB-style port; pready is always high.
// ---------------------------------------------------------------------------
module aabb_fc_regs #(
    parameter int CW = aabb_fc_pkg::COORD_WIDTH_DEF,
    parameter int DW = aabb_fc_pkg::DIR_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_psel,
    input  logic                                i_penable,
    input  logic                                i_pwrite,
    input  logic [aabb_fc_pkg::CFG_ADDR_W-1:0]  i_paddr,
    input  logic [aabb_fc_pkg::CFG_DATA_W-1:0]  i_pwdata,
    output logic [aabb_fc_pkg::CFG_DATA_W-1:0]  o_prdata,
    output aabb_fc_pkg::t_cfg                   o_cfg
);
    localparam int DATA_W = aabb_fc_pkg::CFG_DATA_W;
    // packed fields past the top data bit read as zero, so storage stops there
    localparam int POS_RW = (3 * CW > DATA_W) ? DATA_W : 3 * CW;
    localparam int DIR_RW = (3 * DW > DATA_W) ? DATA_W : 3 * DW;

    logic [POS_RW-1:0]                  r_cam_pos;
    logic [DIR_RW-1:0]                  r_cam_fwd;
    logic [DIR_RW-1:0]                  r_cam_rgt;
    logic [DIR_RW-1:0]                  r_cam_up;
    logic [aabb_fc_pkg::TAN_W-1:0]      r_tan_v;
    logic [aabb_fc_pkg::TAN_W-1:0]      r_tan_h;
    logic [aabb_fc_pkg::DIST_W-1:0]     r_near;
    logic [aabb_fc_pkg::DIST_W-1:0]     r_far;
    logic                               wr_en;
    aabb_fc_pkg::t_reg_idx              reg_idx;

    assign wr_en   = i_psel & i_penable & i_pwrite;
    assign reg_idx = aabb_fc_pkg::t_reg_idx'(i_paddr[aabb_fc_pkg::CFG_ADDR_W-1:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_pos <= '0;
            r_cam_fwd <= '0;
            r_cam_rgt <= '0;
            r_cam_up  <= '0;
            r_tan_v   <= aabb_fc_pkg::TAN_V_RST;
            r_tan_h   <= aabb_fc_pkg::TAN_H_RST;
            r_near    <= aabb_fc_pkg::NEAR_RST;
            r_far     <= aabb_fc_pkg::FAR_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                aabb_fc_pkg::REG_CAM_POS: r_cam_pos <= i_pwdata[POS_RW-1:0];
                aabb_fc_pkg::REG_CAM_FWD: r_cam_fwd <= i_pwdata[DIR_RW-1:0];
                aabb_fc_pkg::REG_CAM_RGT: r_cam_rgt <= i_pwdata[DIR_RW-1:0];
                aabb_fc_pkg::REG_CAM_UP:  r_cam_up  <= i_pwdata[DIR_RW-1:0];
                aabb_fc_pkg::REG_TAN_V:   r_tan_v   <= i_pwdata[aabb_fc_pkg::TAN_W-1:0];
                aabb_fc_pkg::REG_TAN_H:   r_tan_h   <= i_pwdata[aabb_fc_pkg::TAN_W-1:0];
                aabb_fc_pkg::REG_NEAR:    r_near    <= i_pwdata[aabb_fc_pkg::DIST_W-1:0];
                aabb_fc_pkg::REG_FAR:     r_far     <= i_pwdata[aabb_fc_pkg::DIST_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cfg.cam_pos   = DATA_W'(r_cam_pos);
        o_cfg.cam_fwd   = DATA_W'(r_cam_fwd);
        o_cfg.cam_rgt   = DATA_W'(r_cam_rgt);
        o_cfg.cam_up    = DATA_W'(r_cam_up);
        o_cfg.tan_v     = r_tan_v;
        o_cfg.tan_h     = r_tan_h;
        o_cfg.near_dist = r_near;
        o_cfg.far_dist  = r_far;
    end

    always_comb begin
        unique case (reg_idx)
            aabb_fc_pkg::REG_CAM_POS: o_prdata = o_cfg.cam_pos;
            aabb_fc_pkg::REG_CAM_FWD: o_prdata = o_cfg.cam_fwd;
            aabb_fc_pkg::REG_CAM_RGT: o_prdata = o_cfg.cam_rgt;
            aabb_fc_pkg::REG_CAM_UP:  o_prdata = o_cfg.cam_up;
            aabb_fc_pkg::REG_TAN_V:   o_prdata = DATA_W'(r_tan_v);
            aabb_fc_pkg::REG_TAN_H:   o_prdata = DATA_W'(r_tan_h);
            aabb_fc_pkg::REG_NEAR:    o_prdata = DATA_W'(r_near);
            aabb_fc_pkg::REG_FAR:     o_prdata = DATA_W'(r_far);
            default:                  o_prdata = '0;
        endcase
    end

endmodule

[sv/aabb_fc_prep.sv]
// ---------------------------------------------------------------------------
// aabb_fc_prep
// Stage 1: doubled centre offset and extent per axis, degenerate and
// camera-inside flags.
// ---------------------------------------------------------------------------
module aabb_fc_prep #(
    parameter int CW = aabb_fc_pkg::COORD_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [CW-1:0]    i_min [3],
    input  logic signed [CW-1:0]    i_max [3],
    input  aabb_fc_pkg::t_cfg       i_cfg,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [CW+1:0]    o_tc [3],
    output logic signed [CW:0]      o_ex [3],
    output logic                    o_degen,
    output logic                    o_inside
);
    localparam int TC_W   = CW + 2;
    localparam int EX_W   = CW + 1;
    localparam int DATA_W = aabb_fc_pkg::CFG_DATA_W;

    logic [3*CW-1:0]            pos_ext;
    logic signed [CW-1:0]       cam [3];
    logic signed [TC_W-1:0]     n_tc [3];
    logic signed [EX_W-1:0]     n_ex [3];
    logic                       n_degen;
    logic                       n_inside;
    logic signed [TC_W-1:0]     r_tc [3];
    logic signed [EX_W-1:0]     r_ex [3];
    logic                       r_degen;
    logic                       r_inside;
    logic                       r_vld;
    logic                       en;

    assign en      = ~r_vld | i_ready;
    assign o_ready = en;
    assign o_valid = r_vld;

    always_comb begin
        for (int b = 0; b < 3 * CW; b++) begin
            pos_ext[b] = (b < DATA_W) ? i_cfg.cam_pos[b % DATA_W] : 1'b0;
        end
        for (int i = 0; i < 3; i++) begin
            cam[i] = pos_ext[i*CW +: CW];
        end
    end

    always_comb begin
        n_degen  = 1'b1;
        n_inside = 1'b1;
        for (int i = 0; i < 3; i++) begin
            n_tc[i] = TC_W'(i_min[i]) + TC_W'(i_max[i]) - (TC_W'(cam[i]) <<< 1);
            n_ex[i] = EX_W'(i_max[i]) - EX_W'(i_min[i]);
            if (i_min[i] != i_max[i]) begin
                n_degen = 1'b0;
            end
            if (cam[i] < i_min[i] || cam[i] > i_max[i]) begin
                n_inside = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (en) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tc     <= n_tc;
            r_ex     <= n_ex;
            r_degen  <= n_degen;
            r_inside <= n_inside;
        end
    end

    assign o_tc     = r_tc;
    assign o_ex     = r_ex;
    assign o_degen  = r_degen;
    assign o_inside = r_inside;

endmodule

[sv/aabb_fc_dot.sv]
// ---------------------------------------------------------------------------
// aabb_fc_dot
// Stages 2-3: projection onto forward/right/up. Stage 2 holds the nine
// centre and nine extent products, stage 3 the per-axis sums.
// ---------------------------------------------------------------------------
module aabb_fc_dot #(
    parameter int CW = aabb_fc_pkg::COORD_WIDTH_DEF,
    parameter int DW = aabb_fc_pkg::DIR_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [CW+1:0]        i_tc [3],
    input  logic signed [CW:0]          i_ex [3],
    input  logic                        i_degen,
    input  logic                        i_inside,
    input  aabb_fc_pkg::t_cfg           i_cfg,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [CW+DW+3:0]     o_ctr [3],
    output logic signed [CW+DW+3:0]     o_rad [3],
    output logic                        o_degen,
    output logic                        o_inside
);
    localparam int PW     = CW + DW + 2;
    localparam int SW     = PW + 2;
    localparam int DATA_W = aabb_fc_pkg::CFG_DATA_W;

    // axis index: 0 forward, 1 right, 2 up
    logic [DATA_W-1:0]          dir_raw [3];
    logic [3*DW-1:0]            dir_ext [3];
    logic signed [DW-1:0]       dir [3][3];
    logic signed [DW:0]         dabs [3][3];

    logic signed [PW-1:0]       n_pc [3][3];
    logic signed [PW-1:0]       n_pe [3][3];
    logic signed [PW-1:0]       r_pc [3][3];
    logic signed [PW-1:0]       r_pe [3][3];
    logic signed [SW-1:0]       n_ctr [3];
    logic signed [SW-1:0]       n_rad [3];
    logic signed [SW-1:0]       r_ctr [3];
    logic signed [SW-1:0]       r_rad [3];
    logic [1:0]                 r_vld;
    logic [1:0]                 r_degen;
    logic [1:0]                 r_inside;
    logic [1:0]                 en;

    assign en[1]   = ~r_vld[1] | i_ready;
    assign en[0]   = ~r_vld[0] | en[1];
    assign o_ready = en[0];
    assign o_valid = r_vld[1];

    assign dir_raw[0] = i_cfg.cam_fwd;
    assign dir_raw[1] = i_cfg.cam_rgt;
    assign dir_raw[2] = i_cfg.cam_up;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            for (int b = 0; b < 3 * DW; b++) begin
                dir_ext[j][b] = (b < DATA_W) ? dir_raw[j][b % DATA_W] : 1'b0;
            end
            for (int i = 0; i < 3; i++) begin
                dir[j][i]  = dir_ext[j][i*DW +: DW];
                dabs[j][i] = (dir[j][i] < 0) ? -((DW+1)'(dir[j][i])) : (DW+1)'(dir[j][i]);
            end
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            for (int i = 0; i < 3; i++) begin
                n_pc[j][i] = i_tc[i] * dir[j][i];
                n_pe[j][i] = i_ex[i] * dabs[j][i];
            end
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_ctr[j] = SW'(r_pc[j][0]) + SW'(r_pc[j][1]) + SW'(r_pc[j][2]);
            n_rad[j] = SW'(r_pe[j][0]) + SW'(r_pe[j][1]) + SW'(r_pe[j][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            if (en[1]) begin
                r_vld[1] <= r_vld[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_pc        <= n_pc;
            r_pe        <= n_pe;
            r_degen[0]  <= i_degen;
            r_inside[0] <= i_inside;
        end
        if (en[1]) begin
            r_ctr       <= n_ctr;
            r_rad       <= n_rad;
            r_degen[1]  <= r_degen[0];
            r_inside[1] <= r_inside[0];
        end
    end

    assign o_ctr    = r_ctr;
    assign o_rad    = r_rad;
    assign o_degen  = r_degen[1];
    assign o_inside = r_inside[1];

endmodule

[sv/aabb_fc_test.sv]
// ---------------------------------------------------------------------------
// aabb_fc_test
// Stages 4-6: near/far test and side distances, then the two tangent
// products, then the side compares and the final decision.
// ---------------------------------------------------------------------------
module aabb_fc_test #(
    parameter int CW = aabb_fc_pkg::COORD_WIDTH_DEF,
    parameter int DW = aabb_fc_pkg::DIR_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [CW+DW+3:0]     i_ctr [3],
    input  logic signed [CW+DW+3:0]     i_rad [3],
    input  logic                        i_degen,
    input  logic                        i_inside,
    input  aabb_fc_pkg::t_cfg           i_cfg,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_visible
);
    localparam int SW    = CW + DW + 4;
    localparam int DISTW = aabb_fc_pkg::DIST_W + DW;
    localparam int AW    = (SW + 2 > DISTW) ? SW + 2 : DISTW;
    localparam int PRW   = AW + aabb_fc_pkg::TAN_W;
    localparam int CMPW  = PRW + 1;

    logic signed [AW-1:0]   near_v;
    logic signed [AW-1:0]   far_v;
    logic signed [AW-1:0]   front;
    logic signed [AW-1:0]   back;
    logic signed [AW-1:0]   cr_abs;
    logic signed [AW-1:0]   cu_abs;
    logic signed [AW-1:0]   n4_fmax;
    logic signed [AW-1:0]   n4_lhs_h;
    logic signed [AW-1:0]   n4_lhs_v;
    logic                   n4_cull;
    logic [PRW-1:0]         n5_prod_h;
    logic [PRW-1:0]         n5_prod_v;
    logic                   side_h;
    logic                   side_v;
    logic                   n6_vis;

    logic signed [AW-1:0]   r4_fmax;
    logic signed [AW-1:0]   r4_lhs_h;
    logic signed [AW-1:0]   r4_lhs_v;
    logic                   r4_cull;
    logic [PRW-1:0]         r5_prod_h;
    logic [PRW-1:0]         r5_prod_v;
    logic signed [AW-1:0]   r5_lhs_h;
    logic signed [AW-1:0]   r5_lhs_v;
    logic                   r5_cull;
    logic [1:0]             r_degen;
    logic [1:0]             r_inside;
    logic                   r_vis;
    logic [2:0]             r_vld;
    logic [2:0]             en;

    assign en[2]   = ~r_vld[2] | i_ready;
    assign en[1]   = ~r_vld[1] | en[2];
    assign en[0]   = ~r_vld[0] | en[1];
    assign o_ready = en[0];
    assign o_valid = r_vld[2];

    // stage 4: distances share the doubled scale of the projections
    always_comb begin
        near_v   = signed'(AW'(i_cfg.near_dist)) <<< (DW - 1);
        far_v    = signed'(AW'(i_cfg.far_dist)) <<< (DW - 1);
        front    = AW'(i_ctr[0]) + AW'(i_rad[0]);
        back     = AW'(i_ctr[0]) - AW'(i_rad[0]);
        cr_abs   = (i_ctr[1] < 0) ? -AW'(i_ctr[1]) : AW'(i_ctr[1]);
        cu_abs   = (i_ctr[2] < 0) ? -AW'(i_ctr[2]) : AW'(i_ctr[2]);
        n4_cull  = (front < near_v) || (back > far_v);
        n4_fmax  = (front < near_v) ? near_v : front;
        n4_lhs_h = cr_abs - AW'(i_rad[1]);
        n4_lhs_v = cu_abs - AW'(i_rad[2]);
    end

    // stage 5: fmax is never negative here
    always_comb begin
        n5_prod_h = PRW'(unsigned'(r4_fmax)) * PRW'(i_cfg.tan_h);
        n5_prod_v = PRW'(unsigned'(r4_fmax)) * PRW'(i_cfg.tan_v);
    end

    // stage 6: a non-positive side distance never exceeds the product
    always_comb begin
        side_h = (CMPW'(r5_lhs_h) <<< aabb_fc_pkg::TAN_FRAC) > signed'({1'b0, r5_prod_h});
        side_v = (CMPW'(r5_lhs_v) <<< aabb_fc_pkg::TAN_FRAC) > signed'({1'b0, r5_prod_v});
        n6_vis = ~r_degen[1] & (r_inside[1] | ~(r5_cull | side_h | side_v));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            if (en[1]) begin
                r_vld[1] <= r_vld[0];
            end
            if (en[2]) begin
                r_vld[2] <= r_vld[1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r4_fmax     <= n4_fmax;
            r4_lhs_h    <= n4_lhs_h;
            r4_lhs_v    <= n4_lhs_v;
            r4_cull     <= n4_cull;
            r_degen[0]  <= i_degen;
            r_inside[0] <= i_inside;
        end
        if (en[1]) begin
            r5_prod_h   <= n5_prod_h;
            r5_prod_v   <= n5_prod_v;
            r5_lhs_h    <= r4_lhs_h;
            r5_lhs_v    <= r4_lhs_v;
            r5_cull     <= r4_cull;
            r_degen[1]  <= r_degen[0];
            r_inside[1] <= r_inside[0];
        end
        if (en[2]) begin
            r_vis <= n6_vis;
        end
    end

    assign o_visible = r_vis;

endmodule

[sv/aabb_fc_checker.sv]
// ---------------------------------------------------------------------------
// aabb_fc_checker
// Port-level checks for the culling core, bound to the top level.
// ---------------------------------------------------------------------------
module aabb_fc_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 s_tready,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [aabb_fc_pkg::TDATA_OUT_W-1:0]  m_tdata,
    input logic                                 psel,
    input logic                                 penable,
    input logic                                 pwrite,
    input logic [aabb_fc_pkg::CFG_ADDR_W-1:0]   paddr,
    input logic [aabb_fc_pkg::CFG_DATA_W-1:0]   pwdata,
    input logic [aabb_fc_pkg::CFG_DATA_W-1:0]   prdata
);
    localparam int AW = aabb_fc_pkg::CFG_ADDR_W;

    // held result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid right after reset");

    // input side only backs up when the whole pipe is full behind a stall
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled with output free");

    a_tan_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(psel && penable && pwrite && paddr[AW-1:3] == aabb_fc_pkg::REG_TAN_V)
        && psel && !pwrite && paddr[AW-1:3] == aabb_fc_pkg::REG_TAN_V
        |-> prdata == aabb_fc_pkg::CFG_DATA_W'($past(pwdata[aabb_fc_pkg::TAN_W-1:0])))
        else $error("tangent register readback mismatch");

endmodule

bind aabb_frustum_cull_core aabb_fc_checker u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata)
);

[tb/aabb_cull_monitor.sv]
// ---------------------------------------------------------------------------
// aabb_cull_monitor
// Watches the box, result and register channels of the culling core, keeps
// its own copy of the camera registers, works out the visible flag of every
// box that transfers in and compares it with the results in order.
// ---------------------------------------------------------------------------
module aabb_cull_monitor
    import aabb_fc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int DIR_WIDTH   = DIR_WIDTH_DEF,
    localparam int S_W        = ((6 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    // min_x, min_y, min_z, max_x, max_y, max_z (lowest first), zero pad
    input  logic [S_W-1:0]         s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    // visible in bit 0, zero pad
    input  logic [TDATA_OUT_W-1:0] m_tdata,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [CFG_ADDR_W-1:0]  paddr,
    input  logic [CFG_DATA_W-1:0]  pwdata,
    input  logic                   pready,
    output int                     o_errors,
    output int                     o_pending
);

    localparam int CW = COORD_WIDTH;
    localparam int DW = DIR_WIDTH;

    logic [63:0]       cam_pos_q;
    logic [63:0]       cam_fwd_q;
    logic [63:0]       cam_rgt_q;
    logic [63:0]       cam_up_q;
    logic [TAN_W-1:0]  tan_v_q;
    logic [TAN_W-1:0]  tan_h_q;
    logic [DIST_W-1:0] near_q;
    logic [DIST_W-1:0] far_q;

    bit expected_visible[$];
    int mismatches = 0;
    int results_seen = 0;
    bit want;

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    // Signed field k of a packed register; anything past bit 63 reads as zero.
    function automatic longint reg_field(input logic [63:0] word, input int k, input int w);
        logic [127:0] shifted;
        longint v;
        shifted = {64'd0, word} >> (k * w);
        v = longint'(shifted[63:0] & ((64'd1 << w) - 64'd1));
        if (v[w-1])
            v = v - (longint'(1) << w);
        return v;
    endfunction

    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // lhs * 2^TAN_FRAC > fmax * tan, exact
    function automatic bit past_side(input longint lhs, input longint fmax,
                                     input logic [TAN_W-1:0] tan);
        logic [127:0] lhs_s;
        logic [127:0] rhs_s;
        if (lhs <= 0)
            return 1'b0;
        lhs_s = 128'(lhs) << TAN_FRAC;
        rhs_s = 128'(fmax) * 128'(tan);
        return lhs_s > rhs_s;
    endfunction

    function automatic bit box_in_view(input logic [S_W-1:0] box);
        longint lo[3], hi[3], cam[3], fw[3], rt[3], uv[3];
        longint fc, rc, uc, fr, rr, ur, ctr2, ext2, near_s, far_s, fmax;
        bit encloses_cam;
        int k;
        fc = 0; rc = 0; uc = 0; fr = 0; rr = 0; ur = 0;
        for (k = 0; k < 3; k++) begin
            lo[k]  = longint'($signed(box[k*CW +: CW]));
            hi[k]  = longint'($signed(box[(k+3)*CW +: CW]));
            cam[k] = reg_field(cam_pos_q, k, CW);
            fw[k]  = reg_field(cam_fwd_q, k, DW);
            rt[k]  = reg_field(cam_rgt_q, k, DW);
            uv[k]  = reg_field(cam_up_q, k, DW);
        end
        if (lo[0] == hi[0] && lo[1] == hi[1] && lo[2] == hi[2])
            return 1'b0;
        encloses_cam = 1'b1;
        for (k = 0; k < 3; k++)
            if (cam[k] < lo[k] || cam[k] > hi[k])
                encloses_cam = 1'b0;
        if (encloses_cam)
            return 1'b1;
        // centre and extent kept doubled so everything stays integer
        for (k = 0; k < 3; k++) begin
            ctr2 = lo[k] + hi[k] - 2 * cam[k];
            ext2 = hi[k] - lo[k];
            fc += ctr2 * fw[k];
            rc += ctr2 * rt[k];
            uc += ctr2 * uv[k];
            fr += ext2 * mag(fw[k]);
            rr += ext2 * mag(rt[k]);
            ur += ext2 * mag(uv[k]);
        end
        near_s = longint'(near_q) << (DW - 1);
        far_s  = longint'(far_q) << (DW - 1);
        if (fc + fr < near_s)
            return 1'b0;
        if (fc - fr > far_s)
            return 1'b0;
        fmax = (fc + fr < near_s) ? near_s : fc + fr;
        if (past_side(mag(rc) - rr, fmax, tan_h_q))
            return 1'b0;
        if (past_side(mag(uc) - ur, fmax, tan_v_q))
            return 1'b0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("ERROR: result %0d: %s (got %0d, expected %0d)",
                 results_seen, what, got, exp_val);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cam_pos_q = '0;
            cam_fwd_q = '0;
            cam_rgt_q = '0;
            cam_up_q  = '0;
            tan_v_q   = TAN_V_RST;
            tan_h_q   = TAN_H_RST;
            near_q    = NEAR_RST;
            far_q     = FAR_RST;
            expected_visible.delete();
        end else begin
            if (s_tvalid && s_tready)
                expected_visible.push_back(box_in_view(s_tdata));
            if (m_tvalid && m_tready) begin
                if (expected_visible.size() == 0) begin
                    report_mismatch("result transfer with no box pending", m_tdata[0], -1);
                end else begin
                    want = expected_visible.pop_front();
                    if (m_tdata[0] !== want)
                        report_mismatch("visible flag", m_tdata[0], want);
                end
                results_seen++;
            end
            // register mirror; the core is idle whenever this fires
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[CFG_ADDR_W-1:3]))
                    REG_CAM_POS: cam_pos_q = pwdata;
                    REG_CAM_FWD: cam_fwd_q = pwdata;
                    REG_CAM_RGT: cam_rgt_q = pwdata;
                    REG_CAM_UP:  cam_up_q  = pwdata;
                    REG_TAN_V:   tan_v_q   = pwdata[TAN_W-1:0];
                    REG_TAN_H:   tan_h_q   = pwdata[TAN_W-1:0];
                    REG_NEAR:    near_q    = pwdata[DIST_W-1:0];
                    REG_FAR:     far_q     = pwdata[DIST_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending <= expected_visible.size();
        o_errors  <= mismatches;
    end

endmodule

[tb/tb_aabb_frustum_cull_core.sv]
// ---------------------------------------------------------------------------
// tb_aabb_frustum_cull_core
// Drives boxes and camera register writes into the culling core under random
// valid/ready gaps, long output stalls and drained phase changes; the monitor
// beside the core predicts and checks every visible flag.
// ---------------------------------------------------------------------------
module tb_aabb_frustum_cull_core;
    import aabb_fc_pkg::*;

    localparam int CW          = COORD_WIDTH_DEF;
    localparam int S_W         = ((6 * CW + 7) / 8) * 8;
    localparam int HOLD_CYCLES = 64;
    localparam int STALL_LIMIT = 2000;
    localparam int PER_PHASE   = 90;
    localparam int ONE         = 16384;    // 1.0 in Q1.14

    logic                   i_clk    = 1'b0;
    logic                   i_rst_n  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_W-1:0]         s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0]  paddr    = '0;
    logic [CFG_DATA_W-1:0]  pwdata   = '0;
    logic [CFG_DATA_W-1:0]  prdata;
    logic                   pready;

    int errors;
    int pending;
    int src_idle_pct  = 36;
    int sink_idle_pct = 36;
    int hold_req      = 0;
    int hold_done     = 0;
    int hold_left     = 0;
    int stall_cycles  = 0;
    int cam_x, cam_y, cam_z;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    aabb_frustum_cull_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    aabb_cull_monitor monitor (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .pready   (pready),
        .o_errors (errors),
        .o_pending(pending)
    );

    // Result side: random backpressure, plus a long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_done != hold_req) begin
            hold_done <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            stall_cycles <= 0;
        else if (stall_cycles == STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else
            stall_cycles <= stall_cycles + 1;
    end

    function automatic logic [63:0] pack_coords(input int x, input int y, input int z);
        return 64'({z[CW-1:0], y[CW-1:0], x[CW-1:0]});
    endfunction

    function automatic logic [63:0] pack_dirs(input int x, input int y, input int z);
        return 64'({z[15:0], y[15:0], x[15:0]});
    endfunction

    function automatic logic [S_W-1:0] pack_box(input int ax, input int ay, input int az,
                                                 input int bx, input int by, input int bz);
        return S_W'({bz[CW-1:0], by[CW-1:0], bx[CW-1:0], az[CW-1:0], ay[CW-1:0], ax[CW-1:0]});
    endfunction

    function automatic int rand_dir();
        return int'($urandom_range(2 * ONE)) - ONE;
    endfunction

    function automatic int rand_offset(input int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    // Mostly boxes scattered around the camera at a random scale, with some
    // degenerate, camera-enclosing, inverted and fully random ones mixed in.
    function automatic logic [S_W-1:0] random_box();
        int lo[3], hi[3], cam[3];
        int span, kind, k, t;
        cam[0] = cam_x;
        cam[1] = cam_y;
        cam[2] = cam_z;
        kind = $urandom_range(99);
        span = 64 << (2 * $urandom_range(5));
        for (k = 0; k < 3; k++) begin
            lo[k] = cam[k] + rand_offset(span);
            hi[k] = lo[k] + int'($urandom_range(span));
        end
        if (kind < 10) begin
            for (k = 0; k < 3; k++) begin
                lo[k] = $urandom;
                hi[k] = $urandom;
            end
        end else if (kind < 16) begin
            for (k = 0; k < 3; k++)
                hi[k] = lo[k];
        end else if (kind < 22) begin
            for (k = 0; k < 3; k++) begin
                lo[k] = cam[k] - int'($urandom_range(span));
                hi[k] = cam[k] + int'($urandom_range(span));
            end
        end else if (kind < 28) begin
            k = $urandom_range(2);
            t = lo[k];
            lo[k] = hi[k] + 1;
            hi[k] = t;
        end
        return pack_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
    endfunction

    task automatic cfg_write(input t_reg_idx idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Unused upper bits of the narrow registers get random junk.
    task automatic set_view(input logic [63:0] pos, input logic [63:0] fwd,
                            input logic [63:0] rgt, input logic [63:0] upv,
                            input logic [15:0] tv, input logic [15:0] th,
                            input logic [18:0] nr, input logic [18:0] fr);
        cfg_write(REG_CAM_POS, pos);
        cfg_write(REG_CAM_FWD, fwd);
        cfg_write(REG_CAM_RGT, rgt);
        cfg_write(REG_CAM_UP, upv);
        cfg_write(REG_TAN_V, {32'($urandom), 16'($urandom), tv});
        cfg_write(REG_TAN_H, {32'($urandom), 16'($urandom), th});
        cfg_write(REG_NEAR, {32'($urandom), 13'($urandom), nr});
        cfg_write(REG_FAR, {32'($urandom), 13'($urandom), fr});
        cam_x = $signed(pos[CW-1:0]);
        cam_y = $signed(pos[2*CW-1:CW]);
        cam_z = $signed(pos[3*CW-1:2*CW]);
    endtask

    task automatic send_box(input logic [S_W-1:0] box);
        s_tvalid <= 1'b1;
        s_tdata  <= box;
        do @(posedge i_clk); while (!s_tready);
        if ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
    endtask

    // Drops valid, lets the last transfer reach the pending count, then waits for it to empty.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    initial begin
        int ph, n;
        cam_x = 0;
        cam_y = 0;
        cam_z = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset registers: zero directions, camera at the origin
        send_box(pack_box(0, 0, 0, 0, 0, 0));
        send_box(pack_box(-524288, -524288, -524288, -524288, -524288, -524288));
        send_box(pack_box(524287, 524287, 524287, 524287, 524287, 524287));
        send_box(pack_box(-524288, -524288, -524288, 524287, 524287, 524287));
        send_box(pack_box(-64, -64, -64, 64, 64, 64));
        send_box(pack_box(0, 0, 0, 64, 64, 64));
        send_box(pack_box(64, 64, 64, -64, -64, -64));
        send_box(pack_box(100, 0, 0, 200, 0, 0));
        drain();

        // looking down +z from the origin
        set_view(pack_coords(0, 0, 0), pack_dirs(0, 0, ONE), pack_dirs(ONE, 0, 0),
                 pack_dirs(0, ONE, 0), 16'd2365, 16'd4204, 19'd64, 19'd64000);
        send_box(pack_box(-64, -64, 640, 64, 64, 1280));
        send_box(pack_box(-64, -64, -1280, 64, 64, -640));
        send_box(pack_box(-64, -64, 300000, 64, 64, 320000));
        send_box(pack_box(-200000, -64, 640, -190000, 64, 1280));
        send_box(pack_box(-64, 200000, 640, 64, 210000, 1280));
        send_box(pack_box(64, -64, -32, 128, 64, 32));
        send_box(pack_box(64, 64, 1280, -64, -64, 640));
        send_box(pack_box(-524288, -524288, 64, 524287, 524287, 524287));
        send_box(pack_box(524287, -524288, 640, 524287, 524287, 700));
        drain();

        for (ph = 0; ph < 6; ph++) begin
            // phase 1 runs with no idling on either side
            src_idle_pct  = (ph == 1) ? 0 : 36;
            sink_idle_pct <= (ph == 1) ? 0 : 36;
            case (ph)
                0: set_view(pack_coords(0, 0, 0), pack_dirs(0, 0, ONE), pack_dirs(ONE, 0, 0),
                            pack_dirs(0, ONE, 0), 16'd2365, 16'd4204, 19'd64, 19'd64000);
                1: begin
                    // zero near plane
                    set_view(pack_coords(rand_offset(64000), rand_offset(64000),
                                         rand_offset(64000)),
                             pack_dirs(-ONE, 0, 0), pack_dirs(0, 0, ONE),
                             pack_dirs(0, -ONE, 0), 16'd4096, 16'd8192, 19'd0, 19'd128000);
                end
                2: set_view(pack_coords(rand_offset(20000), rand_offset(20000),
                                        rand_offset(20000)),
                            pack_dirs(11585, 0, 11585), pack_dirs(11585, 0, -11585),
                            pack_dirs(0, ONE, 0), 16'd2365, 16'd4204, 19'd32, 19'd6400);
                3: set_view(pack_coords(-524288, 524287, -524288) | {4'hf, 60'd0},
                            pack_dirs(-32768, 32767, -32768) | {16'ha5c3, 48'd0},
                            {$urandom, $urandom}, {$urandom, $urandom},
                            16'd0, 16'd0, 19'd0, 19'h7ffff);
                4: set_view({$urandom, $urandom}, {$urandom, $urandom},
                            {$urandom, $urandom}, {$urandom, $urandom},
                            16'hffff, 16'hffff, 19'h7ffff, 19'd0);
                default: set_view(pack_coords(rand_offset(6400), rand_offset(6400),
                                              rand_offset(6400)),
                                  pack_dirs(rand_dir(), rand_dir(), rand_dir()),
                                  pack_dirs(rand_dir(), rand_dir(), rand_dir()),
                                  pack_dirs(rand_dir(), rand_dir(), rand_dir()),
                                  16'($urandom), 16'($urandom),
                                  19'($urandom_range(640)), 19'($urandom_range(524287, 6400)));
            endcase
            for (n = 0; n < PER_PHASE; n++) begin
                // output held off while boxes keep coming, so the pipe backs up
                if ((ph == 2 || ph == 4) && n == 10)
                    hold_req <= hold_req + 1;
                send_box(random_box());
            end
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[filelist.f]
sv/aabb_fc_pkg.sv
sv/aabb_fc_regs.sv
sv/aabb_fc_prep.sv
sv/aabb_fc_dot.sv
sv/aabb_fc_test.sv
sv/aabb_frustum_cull_core.sv
sv/aabb_fc_checker.sv
tb/aabb_cull_monitor.sv
tb/tb_aabb_frustum_cull_core.sv
